// ----- rtl/nlpr_pkg.sv -----
// ----------------------------------------------------------------------------
// Nonlinear phase rotation package
// Shared types, register codes and constants of the phase rotation block.
// ----------------------------------------------------------------------------
package nlpr_pkg;

  localparam int CFG_AW = 5;

  typedef enum logic [2:0] {
    REG_X_START   = 3'd0,
    REG_Y_START   = 3'd1,
    REG_X_SPACING = 3'd2,
    REG_Y_SPACING = 3'd3,
    REG_COEFF_X   = 3'd4,
    REG_COEFF_Y   = 3'd5,
    REG_G         = 3'd6,
    REG_DT        = 3'd7
  } reg_idx_t;

  localparam logic [34:0] TWO_PI_Q32  = 35'd26986075409;
  localparam logic signed [31:0] TWO_PI_Q28  = 32'sd1686629713;
  localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
  localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
  localparam int TABLE_LEN = 24;

  // CORDIC working word: sample times 2^8 plus growth headroom.
  localparam int CW = 28;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [31:0]   a;
  } cordic_vec_t;

  function automatic logic signed [31:0] atan_q28(input int i);
    logic signed [31:0] t;
    case (i)
      0: t = 32'sd210828714;  1: t = 32'sd124459457;  2: t = 32'sd65760959;
      3: t = 32'sd33381290;   4: t = 32'sd16755422;   5: t = 32'sd8385879;
      6: t = 32'sd4193963;    7: t = 32'sd2097109;    8: t = 32'sd1048571;
      9: t = 32'sd524287;     10: t = 32'sd262144;    11: t = 32'sd131072;
      12: t = 32'sd65536;     13: t = 32'sd32768;     14: t = 32'sd16384;
      15: t = 32'sd8192;      16: t = 32'sd4096;      17: t = 32'sd2048;
      18: t = 32'sd1024;      19: t = 32'sd512;       20: t = 32'sd256;
      21: t = 32'sd128;       22: t = 32'sd64;        default: t = 32'sd32;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/nlpr_if.sv -----
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels carrying the input samples and the rotated results.
// ----------------------------------------------------------------------------
interface nlpr_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        x_index;
  logic [7:0]        y_index;
  logic signed [15:0] psi_re;
  logic signed [15:0] psi_im;
  modport source (output valid, x_index, y_index, psi_re, psi_im, input ready);
  modport sink   (input valid, x_index, y_index, psi_re, psi_im, output ready);
endinterface

interface nlpr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rotated_re;
  logic signed [15:0] rotated_im;
  modport source (output valid, rotated_re, rotated_im, input ready);
  modport sink   (input valid, rotated_re, rotated_im, output ready);
endinterface

// ----- rtl/nonlinear_phase_rotation_unit.sv -----
// ----------------------------------------------------------------------------
// Nonlinear phase rotation unit
// Rotates a wavefunction sample by -(V + g|psi|^2)*dt with a CORDIC chain.
// ----------------------------------------------------------------------------
// Usage: samples enter on the in_ channel (grid indices and Q1.14 psi) and
// one rotated Q1.14 sample leaves on the out_ channel per transaction.
// Registers are to be written through the APB-style cfg_ port only while
// idle; the block itself does not enforce this. The whole datapath is one
// pipeline that advances as a unit: it moves when the output register is
// empty or being taken. A new transaction is accepted every cycle while the
// receiver takes results. Front stages (coordinates, squares, energy, phase,
// quotient, remainder and fold) precede one CORDIC cell per stage, STAGES of
// them (CORDIC_STAGES limited to 24), then gain multiply and rounding.
// Reduction modulo 2*pi is a reciprocal multiply plus a remainder correction.
// When out_ready is low while the output register is full, the pipeline
// holds and in_ready falls. Reset clears all valid bits and restores the
// register defaults; no item is lost or duplicated on stalls.
// ----------------------------------------------------------------------------
module nonlinear_phase_rotation_unit
  import nlpr_pkg::*;
#(
  parameter int GRID_X        = 256,
  parameter int GRID_Y        = 256,
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  nlpr_in_if.sink           in_ch,
  nlpr_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int NS  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int LAT = 7 + NS;

  // Configuration registers.
  logic [23:0] x_start_r, y_start_r, x_sp_r, y_sp_r, cx_r, cy_r, g_r;
  logic [15:0] dt_r;
  logic        wr_en;
  reg_idx_t    widx;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[1:0] == 2'd0);
  assign widx  = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_start_r <= 24'd0;     y_start_r <= 24'd0;
      x_sp_r    <= 24'd65536; y_sp_r    <= 24'd65536;
      cx_r      <= 24'd32768; cy_r      <= 24'd32768;
      g_r       <= 24'd65536; dt_r      <= 16'd655;
    end else if (wr_en) begin
      case (widx)
        REG_X_START:   x_start_r <= cfg_pwdata[23:0];
        REG_Y_START:   y_start_r <= cfg_pwdata[23:0];
        REG_X_SPACING: x_sp_r    <= cfg_pwdata[23:0];
        REG_Y_SPACING: y_sp_r    <= cfg_pwdata[23:0];
        REG_COEFF_X:   cx_r      <= cfg_pwdata[23:0];
        REG_COEFF_Y:   cy_r      <= cfg_pwdata[23:0];
        REG_G:         g_r       <= cfg_pwdata[23:0];
        REG_DT:        dt_r      <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (widx)
      REG_X_START:   cfg_prdata = {8'd0, x_start_r};
      REG_Y_START:   cfg_prdata = {8'd0, y_start_r};
      REG_X_SPACING: cfg_prdata = {8'd0, x_sp_r};
      REG_Y_SPACING: cfg_prdata = {8'd0, y_sp_r};
      REG_COEFF_X:   cfg_prdata = {8'd0, cx_r};
      REG_COEFF_Y:   cfg_prdata = {8'd0, cy_r};
      REG_G:         cfg_prdata = {8'd0, g_r};
      REG_DT:        cfg_prdata = {16'd0, dt_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // Pipeline advance control.
  logic [LAT-1:0] vld_r;
  logic           adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end
  assign out_ch.valid = vld_r[LAT-1];

  // Stage 1: coordinates and magnitude squared.
  logic [7:0] xi, yi;
  logic signed [33:0] cxw, cyw;
  logic signed [23:0] xc_r, yc_r;
  logic [31:0] mag2_r;
  logic signed [15:0] re1_r, im1_r;

  assign xi = 8'((in_ch.x_index) % GRID_X);
  assign yi = 8'((in_ch.y_index) % GRID_Y);
  assign cxw = 34'(signed'(x_start_r)) + $signed({18'd0, xi} * {10'd0, x_sp_r});
  assign cyw = 34'(signed'(y_start_r)) + $signed({18'd0, yi} * {10'd0, y_sp_r});

  function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
    if (v > 34'sd8388607) return 24'sd8388607;
    if (v < -34'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      xc_r   <= sat24(cxw);
      yc_r   <= sat24(cyw);
      mag2_r <= 32'(in_ch.psi_re * in_ch.psi_re) + 32'(in_ch.psi_im * in_ch.psi_im);
      re1_r  <= in_ch.psi_re;
      im1_r  <= in_ch.psi_im;
    end
  end

  // Stage 2: squares floored to Q.16 and the interaction product.
  logic [31:0] xsq_r, ysq_r;
  logic signed [55:0] gm_r;
  logic signed [15:0] re2_r, im2_r;
  logic [47:0] xsq_w, ysq_w;
  assign xsq_w = 48'(xc_r * xc_r);
  assign ysq_w = 48'(yc_r * yc_r);
  always_ff @(posedge clk) begin
    if (adv) begin
      xsq_r <= xsq_w[47:16];
      ysq_r <= ysq_w[47:16];
      gm_r  <= 56'(signed'(g_r)) * $signed({1'b0, mag2_r});
      re2_r <= re1_r;
      im2_r <= im1_r;
    end
  end

  // Stage 3: coefficient products and energy.
  logic signed [41:0] en3_r;
  logic signed [15:0] re3_r, im3_r;
  logic [55:0] px_w, py_w;
  assign px_w = xsq_r * cx_r;
  assign py_w = ysq_r * cy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      en3_r <= 42'(px_w[55:16]) + 42'(py_w[55:16]) + 42'(gm_r >>> 28);
      re3_r <= re2_r;
      im3_r <= im2_r;
    end
  end

  // Stage 4: phase in Q.32 (energy times dt, negated).
  logic signed [58:0] ph4_r;
  logic signed [15:0] re4_r, im4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ph4_r <= -(59'(en3_r) * $signed({1'b0, dt_r}));
      re4_r <= re3_r;
      im4_r <= im3_r;
    end
  end

  // Stage 5: quotient estimate by the reciprocal of 2*pi on the upper phase
  // bits. The estimate is within one of floor(ph / 2*pi); stage 6 corrects it.
  localparam logic [30:0] RECIP = 31'd683565276; // 2^32 / (2*pi), rounded
  logic signed [58:0] ph5_r;
  logic signed [27:0] q5_r;
  logic signed [15:0] re5_r, im5_r;
  logic signed [26:0] ph_hi;
  logic signed [59:0] qp;
  assign ph_hi = ph4_r[58:32];
  assign qp = 60'(ph_hi) * 60'($signed({1'b0, RECIP}));
  always_ff @(posedge clk) begin
    if (adv) begin
      q5_r  <= 28'(qp >>> 32);
      ph5_r <= ph4_r;
      re5_r <= re4_r;
      im5_r <= im4_r;
    end
  end

  // Stage 6: remainder with correction, floor to Q.28, quadrant fold.
  cordic_vec_t v0;
  logic signed [63:0] rr, rr1;
  logic signed [31:0] aa;
  logic signed [CW-1:0] x0, y0;
  always_comb begin
    rr  = 64'(ph5_r) - 64'(q5_r) * $signed({1'b0, TWO_PI_Q32});
    rr1 = rr;
    if (rr1 < 0) rr1 = rr1 + $signed({29'd0, TWO_PI_Q32});
    if (rr1 >= $signed({29'd0, TWO_PI_Q32})) rr1 = rr1 - $signed({29'd0, TWO_PI_Q32});
    if (rr1 >= $signed({29'd0, TWO_PI_Q32})) rr1 = rr1 - $signed({29'd0, TWO_PI_Q32});
    aa = 32'(rr1 >>> 4);
    if (aa >= PI_Q28) aa = aa - TWO_PI_Q28;
    x0 = CW'(re5_r) <<< 8;
    y0 = CW'(im5_r) <<< 8;
    if (aa > HALF_PI_Q28) begin
      aa = aa - PI_Q28; x0 = -x0; y0 = -y0;
    end else if (aa < -HALF_PI_Q28) begin
      aa = aa + PI_Q28; x0 = -x0; y0 = -y0;
    end
    v0.x = x0; v0.y = y0; v0.a = aa;
  end

  cordic_vec_t v6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      v6_r <= v0;
    end
  end

  // CORDIC chain of cells.
  cordic_vec_t chain [NS+1];
  assign chain[0] = v6_r;
  for (genvar s = 0; s < NS; s++) begin : g_cell
    nlpr_cordic_cell #(.STEP(s)) u_cell (
      .clk (clk),
      .en  (adv),
      .vin (chain[s]),
      .vout(chain[s+1])
    );
  end

  // Gain multiply, round and saturate.
  logic signed [59:0] gx, gy;
  logic signed [21:0] rx, ry;
  logic signed [15:0] ore_r, oim_r;
  assign gx = 60'(chain[NS].x) * 60'(GAIN_Q30) + (60'sd1 <<< 37);
  assign gy = 60'(chain[NS].y) * 60'(GAIN_Q30) + (60'sd1 <<< 37);
  assign rx = 22'(gx >>> 38);
  assign ry = 22'(gy >>> 38);

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) return 16'sd32767;
    if (v < -22'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      ore_r <= sat16(rx);
      oim_r <= sat16(ry);
    end
  end
  assign out_ch.rotated_re = ore_r;
  assign out_ch.rotated_im = oim_r;

  // Assertions.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(ore_r))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_angle: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (v6_r.a <= HALF_PI_Q28) && (v6_r.a >= -HALF_PI_Q28))
    else $error("folded angle out of range");

endmodule

// ----- rtl/nlpr_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation micro-step; registers the vector and hands it to the next cell.
// ----------------------------------------------------------------------------
module nlpr_cordic_cell
  import nlpr_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic        en,
  input  cordic_vec_t vin,
  output cordic_vec_t vout
);

  cordic_vec_t vout_r, vout_nxt;
  logic signed [CW-1:0] dx, dy;

  // Rotate toward zero residual angle.
  always_comb begin
    dx = vin.x >>> STEP;
    dy = vin.y >>> STEP;
    if (!vin.a[31]) begin
      vout_nxt.x = vin.x - dy;
      vout_nxt.y = vin.y + dx;
      vout_nxt.a = vin.a - atan_q28(STEP);
    end else begin
      vout_nxt.x = vin.x + dy;
      vout_nxt.y = vin.y - dx;
      vout_nxt.a = vin.a + atan_q28(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vout_r <= vout_nxt;
    end
  end

  assign vout = vout_r;

endmodule

// ----- tb/nonlinear_phase_rotation_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Nonlinear phase rotation unit testbench
// Streams grid samples through the block under several register settings,
// predicts every rotated sample in fixed point and compares each result
// transaction with the oldest prediction. Both channels idle at random, and
// the receiver holds off once for a long stretch so that the pipeline fills.
// ----------------------------------------------------------------------------
module nonlinear_phase_rotation_unit_tb
  import nlpr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TWO_PI_32 = 64'sd26986075409;
  localparam longint TWO_PI_28 = 64'sd1686629713;
  localparam longint PI_28     = 64'sd843314857;
  localparam longint HPI_28    = 64'sd421657428;
  localparam longint GAIN_30   = 64'sd652032874;
  localparam int     STAGES    = 16;
  localparam int     MAX_CYCLES = 400000;

  typedef struct packed {
    logic [7:0]         xi;
    logic [7:0]         yi;
    logic signed [15:0] re;
    logic signed [15:0] im;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } rotated_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  nlpr_in_if  in_ch ();
  nlpr_out_if out_ch ();

  nonlinear_phase_rotation_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Local copy of the register file, kept in step with the writes.
  logic [23:0] x0, y0, dx, dy, cx, cy, g;
  logic [15:0] dt;

  sample_t  pending_samples[$];
  rotated_t expected_rotations[$];
  int errors = 0;
  int cycle_cnt = 0;
  int results_seen = 0;
  bit quiet;
  int hold_left = 0;
  bit held_once = 0;

  // Quiet window: neither side idles here.
  assign quiet = (cycle_cnt >= 3000) && (cycle_cnt < 4500);

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint trap_term(logic [7:0] idx, logic [23:0] start,
                                       logic [23:0] step, logic [23:0] coeff);
    longint c;
    longint sq;
    c = longint'($signed(start)) + longint'(idx) * longint'(step);
    c = sat(c, -64'sd8388608, 64'sd8388607);
    sq = (c * c) >>> 16;
    return (sq * longint'(coeff)) >>> 16;
  endfunction

  // Rotate one sample by -(V + g|psi|^2)*dt.
  function automatic rotated_t rotate_sample(sample_t s);
    longint re, im, mag2, energy, r, a, x, y, ddx, ddy;
    longint atan_tab[24];
    rotated_t o;
    atan_tab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
                 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    re = s.re;
    im = s.im;
    mag2 = re * re + im * im;
    energy = trap_term(s.xi, x0, dx, cx) + trap_term(s.yi, y0, dy, cy)
             + floor_sh(longint'($signed(g)) * mag2, 28);
    r = (-(energy * longint'(dt))) % TWO_PI_32;
    if (r < 0) r += TWO_PI_32;
    a = r >>> 4;
    if (a >= PI_28) a -= TWO_PI_28;
    x = re * 256;
    y = im * 256;
    if (a > HPI_28) begin
      a -= PI_28; x = -x; y = -y;
    end else if (a < -HPI_28) begin
      a += PI_28; x = -x; y = -y;
    end
    for (int i = 0; i < STAGES; i++) begin
      ddx = floor_sh(y, i);
      ddy = floor_sh(x, i);
      if (a >= 0) begin
        x -= ddx; y += ddy; a -= atan_tab[i];
      end else begin
        x += ddx; y -= ddy; a += atan_tab[i];
      end
    end
    x = sat(floor_sh(x * GAIN_30 + (64'sd1 <<< 37), 38), -32768, 32767);
    y = sat(floor_sh(y * GAIN_30 + (64'sd1 <<< 37), 38), -32768, 32767);
    o.re = x[15:0];
    o.im = y[15:0];
    return o;
  endfunction

  // Register write: setup cycle, then access cycle.
  task automatic reg_write(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= {r, 2'b00}; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (r)
      REG_X_START:   x0 = v[23:0];
      REG_Y_START:   y0 = v[23:0];
      REG_X_SPACING: dx = v[23:0];
      REG_Y_SPACING: dy = v[23:0];
      REG_COEFF_X:   cx = v[23:0];
      REG_COEFF_Y:   cy = v[23:0];
      REG_G:         g  = v[23:0];
      default:       dt = v[15:0];
    endcase
  endtask

  task automatic write_all(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, logic [31:0] e, logic [31:0] f,
                           logic [31:0] h, logic [31:0] k);
    reg_write(REG_X_START, a);   reg_write(REG_Y_START, b);
    reg_write(REG_X_SPACING, c); reg_write(REG_Y_SPACING, d);
    reg_write(REG_COEFF_X, e);   reg_write(REG_COEFF_Y, f);
    reg_write(REG_G, h);         reg_write(REG_DT, k);
  endtask

  task automatic push_sample(logic [7:0] xi, logic [7:0] yi,
                             logic [15:0] re, logic [15:0] im);
    sample_t s;
    s.xi = xi; s.yi = yi; s.re = re; s.im = im;
    pending_samples.push_back(s);
  endtask

  // Mostly small grid-like configurations, sometimes full random words.
  task automatic random_setting();
    if ($urandom_range(3) == 0)
      write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    else
      write_all(-$urandom_range(600000), -$urandom_range(600000),
                $urandom_range(8000), $urandom_range(8000),
                $urandom_range(70000), $urandom_range(70000),
                $urandom_range(400000) - 200000, $urandom_range(4000));
  endtask

  // Wait until nothing is queued, offered or in flight.
  task automatic drain();
    while (pending_samples.size() != 0 || in_ch.valid ||
           expected_rotations.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Stimulus and configuration sequence.
  initial begin
    x0 = 24'd0; y0 = 24'd0; dx = 24'd65536; dy = 24'd65536;
    cx = 24'd32768; cy = 24'd32768; g = 24'd65536; dt = 16'd655;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset defaults: field extremes and the origin.
    push_sample(8'd0, 8'd0, 16'h0000, 16'h0000);
    push_sample(8'd0, 8'd0, 16'h4000, 16'h0000);
    push_sample(8'd255, 8'd255, 16'h7fff, 16'h7fff);
    push_sample(8'd255, 8'd0, 16'h8000, 16'h8000);
    push_sample(8'd0, 8'd255, 16'h7fff, 16'h8000);
    push_sample(8'd128, 8'd64, 16'h8000, 16'h7fff);
    push_sample(8'd3, 8'd7, 16'hffff, 16'h0001);
    drain();

    // Free variant: both trap coefficients zero.
    write_all(0, 0, 65536, 65536, 0, 0, 32'h7fffff, 16'hffff);
    push_sample(8'd10, 8'd20, 16'h7fff, 16'h0000);
    push_sample(8'd0, 8'd0, 16'h8000, 16'h8000);
    push_sample(8'd5, 8'd5, 16'h1234, 16'hedcb);
    drain();

    // Saturated coordinates, largest coefficients and the most negative g.
    write_all(32'h800000, 32'h7fffff, 32'hffffff, 32'hffffff, 32'hffffff,
              32'hffffff, 32'h800000, 16'hffff);
    push_sample(8'd0, 8'd0, 16'h7fff, 16'h7fff);
    push_sample(8'd255, 8'd255, 16'h8000, 16'h0000);
    push_sample(8'd1, 8'd200, 16'h0100, 16'hff00);
    drain();

    // Zero time step leaves the sample unrotated apart from CORDIC residual and gain rounding.
    write_all(32'hffffffff, 0, 0, 0, 0, 0, 0, 0);
    push_sample(8'd255, 8'd255, 16'h7fff, 16'h8000);
    push_sample(8'd17, 8'd99, 16'h2000, 16'he000);
    drain();

    // Random part across several settings.
    for (int p = 0; p < 8; p++) begin
      random_setting();
      for (int n = 0; n < 125; n++)
        push_sample($urandom, $urandom, $urandom, $urandom);
      drain();
    end

    if (errors == 0)
      $display("nonlinear_phase_rotation_unit_tb: clean");
    else
      $display("nonlinear_phase_rotation_unit_tb: errors");
    $finish;
  end

  // Input driver; predicts each transaction as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.x_index <= '0; in_ch.y_index <= '0;
      in_ch.psi_re <= '0;  in_ch.psi_im <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_rotations.push_back(rotate_sample(
          {in_ch.x_index, in_ch.y_index, in_ch.psi_re, in_ch.psi_im}));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() > 0 && (quiet || $urandom_range(99) >= 22)) begin
          sample_t s;
          s = pending_samples.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.x_index <= s.xi; in_ch.y_index <= s.yi;
          in_ch.psi_re <= s.re;  in_ch.psi_im <= s.im;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!held_once && results_seen >= 200) begin
      held_once <= 1'b1;
      hold_left <= 300;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(99) >= 22);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_rotations.size() == 0) begin
        errors++;
        $display("%0t: unexpected result re=%0d im=%0d", $realtime,
                 out_ch.rotated_re, out_ch.rotated_im);
      end else begin
        rotated_t e;
        e = expected_rotations.pop_front();
        if (e.re !== out_ch.rotated_re) begin
          errors++;
          $display("%0t: rotated_re expected %0d actual %0d", $realtime,
                   e.re, out_ch.rotated_re);
        end
        if (e.im !== out_ch.rotated_im) begin
          errors++;
          $display("%0t: rotated_im expected %0d actual %0d", $realtime,
                   e.im, out_ch.rotated_im);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("nonlinear_phase_rotation_unit_tb: errors");
      $finish;
    end
  end

endmodule
